// ===== rtl/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exchange sort package
// Shared types and constants of the exchange sort unit: the command flags that
// travel through the queue, the queue depth and the back-end states.
// ----------------------------------------------------------------------------
package aes_pkg;

    // Entries in the queue between front end and back end. Must be a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Classification that the front end attaches to every value.
    typedef struct packed {
        logic keep;   // the value fits in the store
        logic last;   // the value closes the set
    } t_cmd_flags;

    localparam int FLAGS_W = $bits(t_cmd_flags);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ROW_RD,
        ST_ROW_TAKE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_ROW_END,
        ST_EMIT_RD,
        ST_EMIT_TAKE,
        ST_EMIT_HOLD
    } t_back_state;

endpackage

// ===== rtl/aes_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exchange sort input channel
// Valid/ready channel that carries one element of a set and its closing mark.
// ----------------------------------------------------------------------------
interface aes_in_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] value;
    logic                    is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

// ===== rtl/aes_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exchange sort output channel
// Valid/ready channel that carries one sorted element with its flags.
// ----------------------------------------------------------------------------
interface aes_out_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sorted_value;
    logic                    is_last_res;
    logic                    overflow;

    modport source (output valid, output sorted_value, output is_last_res,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input is_last_res,
                    input overflow, output ready);
endinterface

// ===== rtl/ascending_exchange_sort_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascending exchange sort unit
// Collects a set of signed values, sorts it in ascending order by pairwise
// exchange and sends the sorted values back out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel i_in carries one value per transfer; is_last closes the
// set. Up to DEPTH values of a set are kept; later ones are dropped and every
// result of that set then carries overflow. A set always holds at least its
// first value.
// Loading runs at one transfer per cycle. A short queue decouples the input
// from the store, so after a closing transfer the unit still takes a few
// values of the next set before i_in.ready drops for the sort and output.
// The in-place sort shares the single store read port: each compare is a
// read, then a compare and write back. Each result then passes through a
// store read, an output register load and a transfer, which waits for
// o_out.ready.
// The output channel o_out holds its value while the receiver stalls; the
// unit waits in that state and nothing is lost.
// Reset (synchronous, active low) empties the queue and the current set; the
// store itself needs no clearing pass, since only written entries are read.
// ----------------------------------------------------------------------------
module ascending_exchange_sort_unit
    import aes_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aes_in_if.sink    i_in,
    aes_out_if.source o_out
);

    localparam int CMD_W = FLAGS_W + WIDTH;

    // Front end to queue.
    logic             push;
    logic [CMD_W-1:0] push_data;
    logic             q_full;

    // Queue to back end.
    logic             q_valid;
    logic [CMD_W-1:0] q_data;
    logic             q_pop;

    // The front end classifies each value against its own fill count, so it
    // never has to wait for the back end to learn whether a value fits.
    aes_front #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Buffer that lets the input side run while the back end is still busy.
    aes_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // The back end owns the store: it fills it, sorts it in place and reads
    // it out in order.
    aes_back #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/aes_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/aes_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exchange sort front end
// Accepts elements, tracks how full the current set is and tags each element
// as kept or dropped and as closing or not, then pushes it into the queue.
// ----------------------------------------------------------------------------
module aes_front
    import aes_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    aes_in_if.sink                 i_in,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [FLAGS_W+WIDTH-1:0] o_push_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic          accept;
    t_cmd_flags    flags;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        flags.keep = (r_fill < CW'(DEPTH));
        flags.last = i_in.is_last;
        n_fill     = r_fill;
        if (accept) begin
            if (i_in.is_last) begin
                n_fill = '0;
            end else if (flags.keep) begin
                n_fill = r_fill + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_push      = accept;
    assign o_push_data = {flags, i_in.value};

endmodule

// ===== rtl/aes_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exchange sort command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module aes_queue
    import aes_pkg::*;
#(
    parameter int DATA_W = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]    r_wr_ptr;
    logic [QAW-1:0]    r_rd_ptr;
    logic [QCW-1:0]    r_used;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_used == QCW'(QUEUE_DEPTH));
    assign o_valid = (r_used != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_used <= r_used + QCW'(1);
            end else if (do_pop && !do_push) begin
                r_used <= r_used - QCW'(1);
            end
        end
    end

endmodule

// ===== rtl/aes_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exchange sort back end
// Writes kept elements into the store, sorts the closed set in place by
// pairwise exchange and sends the sorted elements out through a register.
// ----------------------------------------------------------------------------
module aes_back
    import aes_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  logic [FLAGS_W+WIDTH-1:0] i_q_data,
    output logic                     o_q_pop,
    aes_out_if.source                o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_back_state             r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_dropped, n_dropped;
    logic [AW-1:0]           r_i, n_i;
    logic [AW-1:0]           r_j, n_j;
    logic [AW-1:0]           r_k, n_k;
    logic signed [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0]        r_out_value, n_out_value;
    logic                    r_out_last, n_out_last;
    logic                    r_out_ovf, n_out_ovf;

    t_cmd_flags              q_flags;
    logic [WIDTH-1:0]        q_value;
    logic [CW-1:0]           i_plus, j_plus, k_plus;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [WIDTH-1:0]        ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [WIDTH-1:0]        ram_rdata;

    assign {q_flags, q_value} = i_q_data;
    assign i_plus = CW'(r_i) + CW'(1);
    assign j_plus = CW'(r_j) + CW'(1);
    assign k_plus = CW'(r_k) + CW'(1);

    aes_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_a         = r_a;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_i;
        ram_wdata   = r_a;
        ram_re      = 1'b0;
        ram_raddr   = r_i;
        o_q_pop     = 1'b0;

        case (r_state)
            ST_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (q_flags.keep) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = q_value;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (q_flags.last) begin
                        n_i     = '0;
                        n_state = ST_ROW_RD;
                    end
                end
            end
            ST_ROW_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_i;
                n_state   = ST_ROW_TAKE;
            end
            ST_ROW_TAKE: begin
                // The last row has no later position, so the set is sorted.
                n_a = ram_rdata;
                if (i_plus >= r_count) begin
                    n_k     = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_j     = i_plus[AW-1:0];
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_j;
                n_state   = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                // The held value stands for position i; a swap writes it to j.
                if (r_a > $signed(ram_rdata)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j;
                    ram_wdata = r_a;
                    n_a       = ram_rdata;
                end
                if (j_plus < r_count) begin
                    n_j     = j_plus[AW-1:0];
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_ROW_END;
                end
            end
            ST_ROW_END: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = r_a;
                n_i       = i_plus[AW-1:0];
                n_state   = ST_ROW_RD;
            end
            ST_EMIT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_k;
                n_state   = ST_EMIT_TAKE;
            end
            ST_EMIT_TAKE: begin
                n_out_value = ram_rdata;
                n_out_last  = (k_plus == r_count);
                n_out_ovf   = r_dropped;
                n_state     = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (o_out.ready) begin
                    if (r_out_last) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_LOAD;
                    end else begin
                        n_k     = k_plus[AW-1:0];
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_a         <= n_a;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out.valid        = (r_state == ST_EMIT_HOLD);
    assign o_out.sorted_value = r_out_value;
    assign o_out.is_last_res  = r_out_last;
    assign o_out.overflow     = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond store depth");

    a_pop_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_LOAD))
        else $error("queue popped outside the load phase");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_RD) |-> (r_j > r_i && CW'(r_j) < r_count))
        else $error("scan position out of order");

    a_set_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_out_last)
        |=> (r_state == ST_LOAD && r_count == '0 && !r_dropped))
        else $error("set not cleared after its final transfer");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exchange sort unit testbench
// Feeds sets of signed values through the input channel and checks each
// sorted result against an in-bench prediction of the sorted set. A short
// table of directed sets comes first, then random sets under four handshake
// phases: free flow, sender gaps, receiver stalls, and both together.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH          = 64;
    localparam int WIDTH          = 32;
    localparam int WATCHDOG_LIMIT = 40000;  // well above the quiet span of a full 64-entry sort
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 12;     // with the directed rows, about 130 items in all

    localparam logic signed [WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One row of the directed table. When typed is set the row closes a
    // one-element set and want is the result read straight off the input.
    typedef struct packed {
        logic signed [WIDTH-1:0] value;
        logic                    last;
        logic                    typed;
        logic signed [WIDTH-1:0] want;
    } t_stim_row;

    typedef struct packed {
        logic signed [WIDTH-1:0] value;
        logic                    last;
        logic                    ovf;
    } t_sorted_rec;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic rx_ready = 1'b0;

    aes_in_if  #(.WIDTH(WIDTH)) in_if ();
    aes_out_if #(.WIDTH(WIDTH)) out_if ();

    assign out_if.ready = rx_ready;

    ascending_exchange_sort_unit #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Predicted contents of the set being collected.
    logic signed [WIDTH-1:0] kept_values [DEPTH];
    int                      kept_count   = 0;
    bit                      set_dropped  = 1'b0;

    // Sorted results still owed by the unit, oldest first.
    t_sorted_rec pending_sorted_q [$];

    int error_count     = 0;
    int results_checked = 0;
    int sets_closed     = 0;
    int overflow_sets   = 0;
    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;

    t_stim_row directed_rows [20];

    // Accounts for one accepted element and, when it closes the set, sorts the
    // kept values by pairwise exchange and queues the sorted results, or the typed result.
    task automatic take_element(input logic signed [WIDTH-1:0] value, input logic last,
                                input logic typed, input logic signed [WIDTH-1:0] want);
        logic signed [WIDTH-1:0] sorted_vals [DEPTH];
        logic signed [WIDTH-1:0] hold;
        if (kept_count < DEPTH) begin
            kept_values[kept_count] = value;
            kept_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) return;

        for (int i = 0; i < kept_count; i++) sorted_vals[i] = kept_values[i];
        for (int i = 0; i < kept_count; i++) begin
            for (int j = i + 1; j < kept_count; j++) begin
                if (sorted_vals[i] > sorted_vals[j]) begin
                    hold           = sorted_vals[i];
                    sorted_vals[i] = sorted_vals[j];
                    sorted_vals[j] = hold;
                end
            end
        end

        if (typed) begin
            pending_sorted_q.push_back('{value: want, last: 1'b1, ovf: 1'b0});
        end else begin
            for (int k = 0; k < kept_count; k++)
                pending_sorted_q.push_back('{value: sorted_vals[k],
                                             last:  (k == kept_count - 1),
                                             ovf:   set_dropped});
        end
        sets_closed++;
        if (set_dropped) overflow_sets++;
        kept_count  = 0;
        set_dropped = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Valid is left high so a following element keeps the channel busy.
    task automatic send_element(input logic signed [WIDTH-1:0] value, input logic last,
                                input logic typed, input logic signed [WIDTH-1:0] want);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.value   <= value;
        in_if.is_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        take_element(value, last, typed, want);
        @(negedge i_clk);
    endtask

    // Receiver side: ready is redrawn at every falling edge.
    always @(negedge i_clk) begin
        rx_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_sorted_rec want_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_sorted_q.size() == 0) begin
                $error("unexpected result: sorted_value %0d is_last_res %0b overflow %0b",
                       out_if.sorted_value, out_if.is_last_res, out_if.overflow);
                error_count++;
            end else begin
                want_r = pending_sorted_q.pop_front();
                if (out_if.sorted_value !== want_r.value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want_r.value, out_if.sorted_value);
                    error_count++;
                end
                if (out_if.is_last_res !== want_r.last) begin
                    $error("is_last_res: expected %0b, got %0b",
                           want_r.last, out_if.is_last_res);
                    error_count++;
                end
                if (out_if.overflow !== want_r.ovf) begin
                    $error("overflow: expected %0b, got %0b", want_r.ovf, out_if.overflow);
                    error_count++;
                end
                results_checked++;
            end
        end
    end

    // Watchdog: too many cycles without any transfer on either channel.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_sorted_q.size());
            $display("** ascending_exchange_sort_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                      set_len;
        int                      phase_items;
        logic signed [WIDTH-1:0] value;

        in_if.valid   = 1'b0;
        in_if.value   = '0;
        in_if.is_last = 1'b0;

        // One-element sets have their result typed in; the others rely on the
        // prediction: both extremes in falling order, duplicates, reversed and
        // already sorted runs, and alternating bit patterns.
        directed_rows = '{
            '{value: 32'sd0,           last: 1'b1, typed: 1'b1, want: 32'sd0},
            '{value: VAL_MAX,          last: 1'b1, typed: 1'b1, want: VAL_MAX},
            '{value: VAL_MIN,          last: 1'b1, typed: 1'b1, want: VAL_MIN},
            '{value: -32'sd1,          last: 1'b1, typed: 1'b1, want: -32'sd1},
            '{value: VAL_MAX,          last: 1'b0, typed: 1'b0, want: '0},
            '{value: VAL_MIN,          last: 1'b1, typed: 1'b0, want: '0},
            '{value: 32'sd5,           last: 1'b0, typed: 1'b0, want: '0},
            '{value: 32'sd5,           last: 1'b0, typed: 1'b0, want: '0},
            '{value: -32'sd5,          last: 1'b1, typed: 1'b0, want: '0},
            '{value: 32'sd3,           last: 1'b0, typed: 1'b0, want: '0},
            '{value: 32'sd2,           last: 1'b0, typed: 1'b0, want: '0},
            '{value: 32'sd1,           last: 1'b0, typed: 1'b0, want: '0},
            '{value: 32'sd0,           last: 1'b1, typed: 1'b0, want: '0},
            '{value: -32'sd2,          last: 1'b0, typed: 1'b0, want: '0},
            '{value: -32'sd1,          last: 1'b0, typed: 1'b0, want: '0},
            '{value: VAL_MAX,          last: 1'b1, typed: 1'b0, want: '0},
            '{value: 32'sh5555_5555,   last: 1'b0, typed: 1'b0, want: '0},
            '{value: 32'shAAAA_AAAA,   last: 1'b0, typed: 1'b0, want: '0},
            '{value: 32'sh8000_0001,   last: 1'b0, typed: 1'b0, want: '0},
            '{value: 32'sh7FFF_FFFE,   last: 1'b1, typed: 1'b0, want: '0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_element(directed_rows[r].value, directed_rows[r].last,
                         directed_rows[r].typed, directed_rows[r].want);

        // Random sets. Most are short; phase 1 opens with a set that fills the
        // store and then overruns it by one or two values, so its closing
        // element is dropped too.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 51; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            // Hold the sender off until the unit has delivered everything owed.
            if (phase == 2) begin
                in_if.valid <= 1'b0;
                do @(negedge i_clk); while (pending_sorted_q.size() != 0);
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (phase == 1 && phase_items == 0)
                    set_len = $urandom_range(DEPTH + 2, DEPTH + 1);
                else if ($urandom_range(9, 0) == 0)
                    set_len = $urandom_range(20, 9);
                else
                    set_len = $urandom_range(8, 1);
                for (int k = 0; k < set_len; k++) begin
                    case ($urandom_range(9, 0))
                        0, 1: value = int'($urandom_range(8, 0)) - 4;
                        2: begin
                            case ($urandom_range(3, 0))
                                0:       value = VAL_MIN;
                                1:       value = VAL_MAX;
                                2:       value = '0;
                                default: value = -32'sd1;
                            endcase
                        end
                        default: value = $urandom;
                    endcase
                    send_element(value, (k == set_len - 1), 1'b0, '0);
                end
                phase_items += set_len;
            end
        end

        in_if.valid <= 1'b0;
        while (pending_sorted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_sorted_q.size() != 0) begin
            $error("%0d sorted results never arrived", pending_sorted_q.size());
            error_count++;
        end

        $display("Run covered %0d sets (%0d overran the store) and %0d checked results,",
                 sets_closed, overflow_sets, results_checked);
        $display("under free flow, sender gaps, receiver stalls and mixed handshakes.");
        if (error_count == 0) begin
            $display("** ascending_exchange_sort_unit: PASSED **");
        end else begin
            $display("** ascending_exchange_sort_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/aes_pkg.sv
rtl/aes_in_if.sv
rtl/aes_out_if.sv
rtl/aes_ram.sv
rtl/aes_front.sv
rtl/aes_queue.sv
rtl/aes_back.sv
rtl/ascending_exchange_sort_unit.sv
dv/testbench.sv
